// ===== src/dppf_pkg.sv =====
// ----------------------------------------------------------------------------
// dppf_pkg
// Shared constants and types for the dual plane pixel framebuffer.
// ----------------------------------------------------------------------------
package dppf_pkg;

    localparam int PLANE_BYTES = 16384;
    localparam int ADDR_W      = $clog2(PLANE_BYTES);
    // index arithmetic width, wide enough for any frame index plus headroom
    localparam int SUM_W       = ADDR_W + 2;

    localparam logic OP_PLOT = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [1:0] COLOR_WHITE  = 2'd0;
    localparam logic [1:0] COLOR_BLACK  = 2'd1;
    localparam logic [1:0] COLOR_THIRD  = 2'd2;
    // leaves both planes as they are
    localparam logic [1:0] COLOR_UNUSED = 2'd3;

    localparam logic PANEL_SMALL = 1'b0;

    // small panel: 250x122, drawn rotated, 17 bytes per device row
    localparam logic [8:0] SMALL_WIDTH     = 9'd250;
    localparam logic [8:0] SMALL_HEIGHT    = 9'd122;
    localparam logic [5:0] SMALL_ROW_BYTES = 6'd17;
    // large panel: 400x300, unrotated, 50 bytes per device row
    localparam logic [8:0] LARGE_WIDTH     = 9'd400;
    localparam logic [8:0] LARGE_HEIGHT    = 9'd300;
    localparam logic [5:0] LARGE_ROW_BYTES = 6'd50;

    localparam logic [SUM_W-1:0] SMALL_FRAME_LEN = SUM_W'(17 * 250);
    localparam logic [SUM_W-1:0] LARGE_FRAME_LEN = SUM_W'(50 * 300);

    // one entry of the combined store: main plane byte low, color plane byte high
    typedef struct packed {
        logic [7:0] color_byte;
        logic [7:0] main_byte;
    } t_entry;

    // decoded item
    typedef struct packed {
        logic              op;
        logic              hit;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        mask;
        logic [1:0]        color;
    } t_map;

endpackage

// ===== src/dual_plane_pixel_framebuffer.sv =====
// ----------------------------------------------------------------------------
// dual_plane_pixel_framebuffer
// Two-plane pixel store for a tri-color e-paper panel: plot and read words.
// ----------------------------------------------------------------------------
// Pipeline: stage 1 registers the input word with its store read, and the
// output register holds the result word after the read-modify-write.
// Throughput: one word per cycle unless the output stalls; the store's single
// read port and the read-modify-write stage set it, with forwarding for
// back-to-back hits. Reset: synchronous, active low. After reset a pass clears
// both planes while s_axis_tready stays low; config writes are taken throughout.
// ----------------------------------------------------------------------------
module dual_plane_pixel_framebuffer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data,      // panel_kind
    // input words
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,    // pixel_x, pixel_y, pixel_color, read_index
    input  logic        s_axis_tuser,    // opcode
    // result words
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,    // main_byte, color_byte
    output logic        m_axis_tuser     // in_range
);
    import dppf_pkg::*;

    logic   r_panel_kind;
    t_map   map;
    logic   clearing;
    t_entry rd_data;

    logic   r_s1_valid;
    t_map   r_s1;
    logic   r_s1_fwd;
    t_entry r_fwd_data;

    logic   r_out_valid;
    logic   r_out_range;
    t_entry r_out_data;

    logic   s1_adv;
    logic   accept;
    t_entry old_data;
    t_entry new_data;
    logic   wr_en;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_panel_kind <= PANEL_SMALL;
        end else if (i_cfg_valid) begin
            r_panel_kind <= i_cfg_data;
        end
    end

    dppf_map u_map (
        .i_panel_kind  (r_panel_kind),
        .i_opcode      (s_axis_tuser),
        .i_pixel_x     (s_axis_tdata[8:0]),
        .i_pixel_y     (s_axis_tdata[17:9]),
        .i_pixel_color (s_axis_tdata[19:18]),
        .i_read_index  (s_axis_tdata[33:20]),
        .o_map         (map)
    );

    assign s1_adv        = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !clearing && (!r_s1_valid || s1_adv);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // read-modify-write stage
    always_comb begin
        old_data = r_s1_fwd ? r_fwd_data : rd_data;
        new_data = old_data;
        case (r_s1.color)
            COLOR_WHITE: begin
                new_data.main_byte  = old_data.main_byte | r_s1.mask;
                new_data.color_byte = old_data.color_byte & ~r_s1.mask;
            end
            COLOR_BLACK: begin
                new_data.main_byte  = old_data.main_byte & ~r_s1.mask;
                new_data.color_byte = old_data.color_byte & ~r_s1.mask;
            end
            COLOR_THIRD: begin
                new_data.main_byte  = old_data.main_byte | r_s1.mask;
                new_data.color_byte = old_data.color_byte | r_s1.mask;
            end
            default: begin
                new_data = old_data;
            end
        endcase
        if (r_s1.op == OP_READ) begin
            new_data = old_data;
        end
    end

    assign wr_en = s1_adv && r_s1.hit && (r_s1.op == OP_PLOT) && (r_s1.color != COLOR_UNUSED);

    dppf_mem u_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (accept),
        .i_rd_addr  (map.addr),
        .o_rd_data  (rd_data),
        .i_wr_en    (wr_en),
        .i_wr_addr  (r_s1.addr),
        .i_wr_data  (new_data),
        .o_clearing (clearing)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // the read issued with this accept sees the old entry if the word ahead
    // writes the same entry in the same cycle, so take its data instead
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1       <= map;
            r_s1_fwd   <= wr_en && (r_s1.addr == map.addr);
            r_fwd_data <= new_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_range <= r_s1.hit;
            r_out_data  <= r_s1.hit ? new_data : '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_range;

endmodule

// ===== src/dppf_map.sv =====
// ----------------------------------------------------------------------------
// dppf_map
// Bounds check, panel rotation and byte/bit address for one item.
// ----------------------------------------------------------------------------
module dppf_map (
    input  logic                 i_panel_kind,
    input  logic                 i_opcode,
    input  logic [8:0]           i_pixel_x,
    input  logic [8:0]           i_pixel_y,
    input  logic [1:0]           i_pixel_color,
    input  logic [13:0]          i_read_index,
    output dppf_pkg::t_map       o_map
);
    import dppf_pkg::*;

    logic             bounds_ok;
    logic [8:0]       col;
    logic [8:0]       row;
    logic [5:0]       row_bytes;
    logic [14:0]      row_ofs;
    logic [SUM_W-1:0] plot_idx;
    logic [SUM_W-1:0] read_idx;
    logic [SUM_W-1:0] frame_len;
    logic [SUM_W-1:0] sel_idx;

    always_comb begin
        if (i_panel_kind == PANEL_SMALL) begin
            bounds_ok = (i_pixel_x < SMALL_WIDTH) && (i_pixel_y < SMALL_HEIGHT);
            // rotated: device column runs against user y
            col       = SMALL_HEIGHT - 9'd1 - i_pixel_y;
            row       = i_pixel_x;
            row_bytes = SMALL_ROW_BYTES;
            frame_len = SMALL_FRAME_LEN;
        end else begin
            bounds_ok = (i_pixel_x < LARGE_WIDTH) && (i_pixel_y < LARGE_HEIGHT);
            col       = i_pixel_x;
            row       = i_pixel_y;
            row_bytes = LARGE_ROW_BYTES;
            frame_len = LARGE_FRAME_LEN;
        end

        row_ofs  = row * row_bytes;
        plot_idx = SUM_W'(col[8:3]) + SUM_W'(row_ofs);
        read_idx = SUM_W'(i_read_index);

        if (i_opcode == OP_READ) begin
            sel_idx   = read_idx;
            o_map.hit = (read_idx < frame_len) && (read_idx < SUM_W'(PLANE_BYTES));
        end else begin
            sel_idx   = plot_idx;
            o_map.hit = bounds_ok && (plot_idx < SUM_W'(PLANE_BYTES));
        end

        o_map.op    = i_opcode;
        o_map.addr  = sel_idx[ADDR_W-1:0];
        o_map.mask  = 8'h80 >> col[2:0];
        o_map.color = i_pixel_color;
    end

endmodule

// ===== src/dppf_mem.sv =====
// ----------------------------------------------------------------------------
// dppf_mem
// Combined main/color plane store, one read and one write port, registered
// read. Sweeps every entry to zero after reset.
// ----------------------------------------------------------------------------
module dppf_mem (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_rd_en,
    input  logic [dppf_pkg::ADDR_W-1:0] i_rd_addr,
    output dppf_pkg::t_entry            o_rd_data,
    input  logic                        i_wr_en,
    input  logic [dppf_pkg::ADDR_W-1:0] i_wr_addr,
    input  dppf_pkg::t_entry            i_wr_data,
    output logic                        o_clearing
);
    import dppf_pkg::*;

    t_entry            r_mem [PLANE_BYTES];
    t_entry            r_rd_data;
    logic              r_clearing;
    logic [ADDR_W-1:0] r_clr_addr;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    t_entry            wr_data;

    always_comb begin
        if (r_clearing) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = '0;
        end else begin
            wr_en   = i_wr_en;
            wr_addr = i_wr_addr;
            wr_data = i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == ADDR_W'(PLANE_BYTES - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_clearing = r_clearing;

endmodule
